FILE: src/edw_pkg.sv
`timescale 1ns / 1ps

package edw_pkg;

    localparam int CNT_W    = 16;
    localparam int DIST_W   = 12;
    localparam int CHAR_W   = 8;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam int REPORT_LEN = 10;
    localparam int IDX_W      = 4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_LOW       = 2'd1;
    localparam logic [1:0] REG_HIGH      = 2'd2;
    localparam logic [1:0] REG_ALARM_THR = 2'd3;

    localparam logic [CNT_W-1:0]  RST_TIMEOUT   = 16'd14592;
    localparam logic [DIST_W-1:0] RST_LOW       = 12'd40;
    localparam logic [DIST_W-1:0] RST_HIGH      = 12'd4000;
    localparam logic [DIST_W-1:0] RST_ALARM_THR = 12'd150;

    // reciprocal constants: floor(x/d) = (x*M) >> S, exact over the stated input width
    localparam logic [21:0] RECIP_100_W21 = 22'd2684355;  // x < 2^21, shift 28
    localparam logic [12:0] RECIP_10_W12  = 13'd6554;     // x < 2^12, shift 16
    localparam logic [9:0]  RECIP_100_W9  = 10'd656;      // x < 2^9,  shift 16
    localparam logic [7:0]  RECIP_10_W7   = 8'd205;       // x < 2^7,  shift 11

    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_M     = 8'h6D;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic [CNT_W-1:0]  timeout_count;
        logic [DIST_W-1:0] low_limit;
        logic [DIST_W-1:0] high_limit;
        logic [DIST_W-1:0] alarm_threshold;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              alarm;
        logic [CHAR_W-1:0] c_hund;
        logic [CHAR_W-1:0] c_tens;
        logic [CHAR_W-1:0] c_ones;
        logic [CHAR_W-1:0] c_frac;
    } t_rpt;

endpackage

FILE: src/edw_calc.sv
`timescale 1ns / 1ps

module edw_calc (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  edw_pkg::t_cfg            i_cfg,
    input  logic                     i_in_vld,
    input  logic [edw_pkg::CNT_W-1:0] i_echo_count,
    output logic                     o_in_rdy,
    output logic                     o_rpt_vld,
    output edw_pkg::t_rpt            o_rpt,
    input  logic                     i_rpt_take
);
    import edw_pkg::*;

    localparam int NSTG = 8;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_rdy;

    // stage payloads
    logic [CNT_W-1:0]  r_p1_cnt;
    logic              r_p2_tmo;
    logic [20:0]       r_p2_prod;
    logic              r_p3_tmo;
    logic [13:0]       r_p3_q;
    logic [DIST_W-1:0] r_p4_dist;
    logic              r_p4_alm;
    logic [DIST_W-1:0] r_p5_dist;
    logic              r_p5_alm;
    logic [8:0]        r_p5_ip;
    logic [DIST_W-1:0] r_p6_dist;
    logic              r_p6_alm;
    logic [8:0]        r_p6_ip;
    logic [3:0]        r_p6_fp;
    logic [2:0]        r_p6_h;
    logic [DIST_W-1:0] r_p7_dist;
    logic              r_p7_alm;
    logic [3:0]        r_p7_fp;
    logic [2:0]        r_p7_h;
    logic [6:0]        r_p7_rem;
    t_rpt              r_p8_rpt;

    logic [42:0]       w_mul100;
    logic [DIST_W-1:0] w_dist;
    logic [24:0]       w_mul10;
    logic [DIST_W-1:0] w_ip10;
    logic [18:0]       w_mulh;
    logic [8:0]        w_h100;
    logic [14:0]       w_mult;
    logic [3:0]        w_t;
    logic [6:0]        w_t10;
    logic [3:0]        w_o;
    t_rpt              w_rpt;

    // a stage loads when it is empty or its word moves on
    always_comb begin
        w_rdy[NSTG] = !r_vld[NSTG] || i_rpt_take;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_rdy  = w_rdy[1];
    assign o_rpt_vld = r_vld[NSTG];
    assign o_rpt     = r_p8_rpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_in_vld;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 3: raw distance = prod / 100
    assign w_mul100 = 43'(r_p2_prod) * 43'(RECIP_100_W21);

    // stage 4: a timeout gives the high limit, else clamp, low limit tested first
    always_comb begin
        if (r_p3_tmo) begin
            w_dist = i_cfg.high_limit;
        end else if (r_p3_q < 14'(i_cfg.low_limit)) begin
            w_dist = i_cfg.low_limit;
        end else if (r_p3_q > 14'(i_cfg.high_limit)) begin
            w_dist = i_cfg.high_limit;
        end else begin
            w_dist = r_p3_q[DIST_W-1:0];
        end
    end

    // stage 5..8: digit split
    assign w_mul10 = 25'(r_p4_dist) * 25'(RECIP_10_W12);
    assign w_ip10  = 12'(r_p5_ip) * 12'd10;
    assign w_mulh  = 19'(r_p5_ip) * 19'(RECIP_100_W9);
    assign w_h100  = 9'(r_p6_h) * 9'd100;
    assign w_mult  = 15'(r_p7_rem) * 15'(RECIP_10_W7);
    assign w_t     = w_mult[14:11];
    assign w_t10   = 7'(w_t) * 7'd10;
    assign w_o     = 4'(r_p7_rem - w_t10);

    always_comb begin
        w_rpt.distance = r_p7_dist;
        w_rpt.alarm    = r_p7_alm;
        w_rpt.c_hund   = (r_p7_h != 3'd0) ? (CHAR_0 | 8'(r_p7_h)) : CHAR_SPACE;
        w_rpt.c_tens   = (r_p7_h != 3'd0 || w_t != 4'd0) ? (CHAR_0 | 8'(w_t)) : CHAR_SPACE;
        w_rpt.c_ones   = CHAR_0 | 8'(w_o);
        w_rpt.c_frac   = CHAR_0 | 8'(r_p7_fp);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_p1_cnt <= i_echo_count;
        end
        if (w_rdy[2]) begin
            r_p2_tmo  <= (r_p1_cnt >= i_cfg.timeout_count);
            r_p2_prod <= {r_p1_cnt, 4'b0} + 21'(r_p1_cnt);
        end
        if (w_rdy[3]) begin
            r_p3_tmo <= r_p2_tmo;
            r_p3_q   <= w_mul100[41:28];
        end
        if (w_rdy[4]) begin
            r_p4_dist <= w_dist;
            r_p4_alm  <= (w_dist < i_cfg.alarm_threshold);
        end
        if (w_rdy[5]) begin
            r_p5_dist <= r_p4_dist;
            r_p5_alm  <= r_p4_alm;
            r_p5_ip   <= w_mul10[24:16];
        end
        if (w_rdy[6]) begin
            r_p6_dist <= r_p5_dist;
            r_p6_alm  <= r_p5_alm;
            r_p6_ip   <= r_p5_ip;
            r_p6_fp   <= 4'(r_p5_dist - w_ip10);
            r_p6_h    <= w_mulh[18:16];
        end
        if (w_rdy[7]) begin
            r_p7_dist <= r_p6_dist;
            r_p7_alm  <= r_p6_alm;
            r_p7_fp   <= r_p6_fp;
            r_p7_h    <= r_p6_h;
            r_p7_rem  <= 7'(r_p6_ip - w_h100);
        end
        if (w_rdy[8]) begin
            r_p8_rpt <= w_rpt;
        end
    end

endmodule

FILE: src/echo_width_to_distance_report.sv
`timescale 1ns / 1ps

// Echo pulse width to distance report.
// Input: raise start with i_echo_count; the word is taken at an edge where
// busy is low. Each word yields a ten-character ASCII report
// ("ddd.d cm" CR LF), one character per cycle marked by o_strobe, with the
// clamped distance and alarm repeated on every character and o_last_char
// on the line feed.
// The word passes through the arithmetic pipeline and then the report
// register before its first character is on the ports.
// Throughput is set by the report shifter, which sends one character per
// cycle. An eight-stage arithmetic pipeline in front of it holds up to eight
// more words; busy rises only when that pipeline is full, and reports go out
// back to back with no gap.
// The receiver cannot stall: o_strobe is a one-cycle mark per character.
// Config: APB registers timeout_count, low_limit, high_limit, alarm_threshold
// at byte addresses 0, 4, 8, 12; write them only while idle.
// Reset (synchronous, active low) empties the pipeline, drops any report in
// flight and loads the register defaults.
module echo_width_to_distance_report (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [edw_pkg::PADDR_W-1:0]  paddr,
    input  logic [edw_pkg::PDATA_W-1:0]  pwdata,
    output logic [edw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [edw_pkg::CNT_W-1:0]    i_echo_count,
    output logic                         o_strobe,
    output logic [edw_pkg::CHAR_W-1:0]   o_out_char,
    output logic                         o_last_char,
    output logic [edw_pkg::DIST_W-1:0]   o_distance_tenths,
    output logic                         o_alarm
);
    import edw_pkg::*;

    t_cfg             r_cfg;
    logic [1:0]       w_reg_idx;
    logic             w_wr;

    logic             w_in_rdy;
    logic             w_rpt_vld;
    t_rpt             w_rpt;
    logic             w_take;

    logic             r_s_act;
    logic [IDX_W-1:0] r_s_idx;
    t_rpt             r_s_rpt;
    logic             w_last;

    // ---- register file ----
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_count   <= RST_TIMEOUT;
            r_cfg.low_limit       <= RST_LOW;
            r_cfg.high_limit      <= RST_HIGH;
            r_cfg.alarm_threshold <= RST_ALARM_THR;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_TIMEOUT:   r_cfg.timeout_count   <= pwdata[CNT_W-1:0];
                REG_LOW:       r_cfg.low_limit       <= pwdata[DIST_W-1:0];
                REG_HIGH:      r_cfg.high_limit      <= pwdata[DIST_W-1:0];
                REG_ALARM_THR: r_cfg.alarm_threshold <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_TIMEOUT:   prdata = PDATA_W'(r_cfg.timeout_count);
            REG_LOW:       prdata = PDATA_W'(r_cfg.low_limit);
            REG_HIGH:      prdata = PDATA_W'(r_cfg.high_limit);
            REG_ALARM_THR: prdata = PDATA_W'(r_cfg.alarm_threshold);
            default:       prdata = '0;
        endcase
    end

    // ---- arithmetic pipeline ----
    edw_calc u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_vld     (start),
        .i_echo_count (i_echo_count),
        .o_in_rdy     (w_in_rdy),
        .o_rpt_vld    (w_rpt_vld),
        .o_rpt        (w_rpt),
        .i_rpt_take   (w_take)
    );

    assign busy = !w_in_rdy;

    // ---- report shifter ----
    assign w_last = (r_s_idx == IDX_W'(REPORT_LEN - 1));
    // next report loads on the line feed cycle so reports run back to back
    assign w_take = w_rpt_vld && (!r_s_act || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_act <= 1'b0;
            r_s_idx <= '0;
        end else if (w_take) begin
            r_s_act <= 1'b1;
            r_s_idx <= '0;
        end else if (r_s_act) begin
            if (w_last) begin
                r_s_act <= 1'b0;
                r_s_idx <= '0;
            end else begin
                r_s_idx <= r_s_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s_rpt <= w_rpt;
        end
    end

    always_comb begin
        case (r_s_idx)
            4'd0:    o_out_char = r_s_rpt.c_hund;
            4'd1:    o_out_char = r_s_rpt.c_tens;
            4'd2:    o_out_char = r_s_rpt.c_ones;
            4'd3:    o_out_char = CHAR_DOT;
            4'd4:    o_out_char = r_s_rpt.c_frac;
            4'd5:    o_out_char = CHAR_SPACE;
            4'd6:    o_out_char = CHAR_C;
            4'd7:    o_out_char = CHAR_M;
            4'd8:    o_out_char = CHAR_CR;
            4'd9:    o_out_char = CHAR_LF;
            default: o_out_char = '0;
        endcase
    end

    assign o_strobe          = r_s_act;
    assign o_last_char       = r_s_act && w_last;
    assign o_distance_tenths = r_s_rpt.distance;
    assign o_alarm           = r_s_rpt.alarm;

`ifndef SYNTHESIS
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> (o_strobe && o_out_char == CHAR_LF))
        else $error("last character is not a line feed");

    a_report_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_char) |=> (o_strobe && $stable(o_distance_tenths)
                                        && $stable(o_alarm)))
        else $error("report broken or distance changed mid-report");

    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_act && !w_last) |=> (r_s_idx == $past(r_s_idx) + 1'b1))
        else $error("character index skipped");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_rpt_vld)
        else $error("busy with an empty pipeline output");
`endif

endmodule

FILE: verif/echo_width_to_distance_report_test.sv
`timescale 1ns / 1ps

module echo_width_to_distance_report_test;

    import edw_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
        logic [DIST_W-1:0] distance;
        logic              alarm;
    } t_report_char;

    // Tracks the register shadow and the report characters still owed by the block.
    class t_report_board;
        logic [CNT_W-1:0]  timeout_count;
        logic [DIST_W-1:0] low_limit;
        logic [DIST_W-1:0] high_limit;
        logic [DIST_W-1:0] alarm_threshold;
        t_report_char      owed_chars[$];
        int                errors;
        int                n_words;
        int                n_chars;
        int                n_settings;
        int                n_timeout;
        int                n_clamped;
        int                n_alarm;

        function new();
            timeout_count   = RST_TIMEOUT;
            low_limit       = RST_LOW;
            high_limit      = RST_HIGH;
            alarm_threshold = RST_ALARM_THR;
            errors = 0;
            n_words = 0;
            n_chars = 0;
            n_settings = 0;
            n_timeout = 0;
            n_clamped = 0;
            n_alarm = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t ns  MISMATCH: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_TIMEOUT:   timeout_count   = value[CNT_W-1:0];
                REG_LOW:       low_limit       = value[DIST_W-1:0];
                REG_HIGH:      high_limit      = value[DIST_W-1:0];
                REG_ALARM_THR: alarm_threshold = value[DIST_W-1:0];
                default: ;
            endcase
            n_settings++;
        endfunction

        function logic [PDATA_W-1:0] reg_value(logic [1:0] idx);
            logic [PDATA_W-1:0] v;
            v = '0;
            case (idx)
                REG_TIMEOUT:   v = PDATA_W'(timeout_count);
                REG_LOW:       v = PDATA_W'(low_limit);
                REG_HIGH:      v = PDATA_W'(high_limit);
                REG_ALARM_THR: v = PDATA_W'(alarm_threshold);
                default: ;
            endcase
            return v;
        endfunction

        function void check_readback(logic [1:0] idx, logic [PDATA_W-1:0] got);
            if (got !== reg_value(idx))
                flag($sformatf("register %0d read 0x%0h, want 0x%0h", idx, got,
                               reg_value(idx)));
        endfunction

        // Work out the ten-character report for one accepted echo word.
        function void note_echo(logic [CNT_W-1:0] count);
            int unsigned       raw;
            int unsigned       distance;
            int unsigned       ip;
            int unsigned       fp;
            logic              alm;
            logic [CHAR_W-1:0] text[REPORT_LEN];
            t_report_char      c;
            n_words++;
            if (count >= timeout_count) begin
                distance = high_limit;
                n_timeout++;
            end else begin
                raw = (32'(count) * 17) / 100;
                // low limit wins when the limits are crossed
                if (raw < low_limit)
                    distance = low_limit;
                else if (raw > high_limit)
                    distance = high_limit;
                else
                    distance = raw;
                if (distance != raw)
                    n_clamped++;
            end
            alm = (distance < alarm_threshold);
            if (alm)
                n_alarm++;
            ip = distance / 10;
            fp = distance % 10;
            text[0] = (ip >= 100) ? CHAR_0 + CHAR_W'(ip / 100) : CHAR_SPACE;
            text[1] = (ip >= 10) ? CHAR_0 + CHAR_W'((ip / 10) % 10) : CHAR_SPACE;
            text[2] = CHAR_0 + CHAR_W'(ip % 10);
            text[3] = CHAR_DOT;
            text[4] = CHAR_0 + CHAR_W'(fp);
            text[5] = CHAR_SPACE;
            text[6] = CHAR_C;
            text[7] = CHAR_M;
            text[8] = CHAR_CR;
            text[9] = CHAR_LF;
            for (int k = 0; k < REPORT_LEN; k++) begin
                c.out_char  = text[k];
                c.last_char = (k == REPORT_LEN - 1);
                c.distance  = DIST_W'(distance);
                c.alarm     = alm;
                owed_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last,
                                 logic [DIST_W-1:0] distance, logic alm);
            t_report_char want;
            if (owed_chars.size() == 0) begin
                flag($sformatf("unexpected char 0x%0h last=%0b dist=%0d alarm=%0b",
                               ch, last, distance, alm));
                return;
            end
            want = owed_chars.pop_front();
            n_chars++;
            if (ch !== want.out_char || last !== want.last_char ||
                distance !== want.distance || alm !== want.alarm)
                flag($sformatf({"char 0x%0h last=%0b dist=%0d alarm=%0b, ",
                                "want 0x%0h last=%0b dist=%0d alarm=%0b"},
                               ch, last, distance, alm,
                               want.out_char, want.last_char, want.distance, want.alarm));
        endfunction

        function int owed();
            return owed_chars.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic [CNT_W-1:0]    i_echo_count;
    logic                o_strobe;
    logic [CHAR_W-1:0]   o_out_char;
    logic                o_last_char;
    logic [DIST_W-1:0]   o_distance_tenths;
    logic                o_alarm;

    t_report_board board;

    echo_width_to_distance_report u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_echo_count      (i_echo_count),
        .o_strobe          (o_strobe),
        .o_out_char        (o_out_char),
        .o_last_char       (o_last_char),
        .o_distance_tenths (o_distance_tenths),
        .o_alarm           (o_alarm)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_char(o_out_char, o_last_char, o_distance_tenths, o_alarm);
    end

    // Word is taken at the first rising edge with busy low; start stays up
    // when the next word follows with no gap.
    task automatic send_echo(logic [CNT_W-1:0] count, int gap);
        @(negedge i_clk);
        start        <= 1'b1;
        i_echo_count <= count;
        do
            @(posedge i_clk);
        while (busy);
        board.note_echo(count);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_reports();
        int guard;
        guard = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (board.owed() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_access(logic [1:0] idx, logic wr, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (wr)
            board.write_reg(idx, value);
        else
            board.check_readback(idx, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(int to, int lo, int hi, int thr);
        drain_reports();
        apb_access(REG_TIMEOUT, 1'b1, PDATA_W'(to));
        apb_access(REG_LOW, 1'b1, PDATA_W'(lo));
        apb_access(REG_HIGH, 1'b1, PDATA_W'(hi));
        apb_access(REG_ALARM_THR, 1'b1, PDATA_W'(thr));
        apb_access(REG_TIMEOUT, 1'b0, '0);
        apb_access(REG_LOW, 1'b0, '0);
        apb_access(REG_HIGH, 1'b0, '0);
        apb_access(REG_ALARM_THR, 1'b0, '0);
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 19))
            12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            18:                     return $urandom_range(4, 12);
            19:                     return $urandom_range(20, 60);
            default:                return 0;
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 4000;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int c;
        int to;
        to = board.timeout_count;
        case ($urandom_range(0, 9))
            0, 1, 2: c = $urandom_range(0, 65535);
            3, 4, 5: c = $urandom_range(0, to - 1);
            6:       c = to + $urandom_range(0, 3) - 2;
            7:       c = $urandom_range(0, 1000);
            8:       c = (board.low_limit * 100) / 17 + $urandom_range(0, 12) - 6;
            default: c = (board.high_limit * 100) / 17 + $urandom_range(0, 12) - 6;
        endcase
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        return CNT_W'(c);
    endfunction

    initial begin
        int lo;
        int hi;
        int to;
        board        = new();
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_echo_count = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: clamp at low limit, alarm edge, 99.9 -> 100.0, timeout edge
        send_echo(16'd0, 0);
        send_echo(16'd1, 1);
        send_echo(16'd235, 0);
        send_echo(16'd236, 0);
        send_echo(16'd882, 2);
        send_echo(16'd883, 0);
        send_echo(16'd5882, 0);
        send_echo(16'd5883, 0);
        send_echo(16'd14591, 3);
        send_echo(16'd14592, 0);
        send_echo(16'hFFFF, 0);
        send_echo(16'hAAAA, 0);
        send_echo(16'h5555, 1);

        // widest window: 0.0 up to full scale, alarm on nearly everything
        set_limits(65535, 0, 4000, 4000);
        send_echo(16'd0, 0);
        send_echo(16'd58, 0);
        send_echo(16'd59, 0);
        send_echo(16'd23529, 0);
        send_echo(16'd23530, 0);
        send_echo(16'd65534, 0);
        send_echo(16'd65535, 0);

        // crossed limits; under the first setting every nonzero count times out
        set_limits(1, 3000, 500, 0);
        send_echo(16'd0, 0);
        send_echo(16'd5, 0);
        set_limits(30000, 3000, 500, 4000);
        send_echo(16'd1000, 0);
        send_echo(16'd20000, 0);
        send_echo(16'd29999, 0);
        send_echo(16'd30000, 0);

        set_limits(65535, 4000, 4000, 0);
        send_echo(16'd100, 0);

        for (int ph = 0; ph < 6; ph++) begin
            to = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ? 1 : 65535)
                                             : $urandom_range(500, 30000);
            lo = pick_limit();
            hi = pick_limit();
            if (lo > hi && $urandom_range(0, 2) != 0) begin
                lo = lo + hi;
                hi = lo - hi;
                lo = lo - hi;
            end
            set_limits(to, lo, hi, pick_limit());
            for (int i = 0; i < 21; i++) begin
                // one hold-off mid-phase until the block has emptied
                if (ph == 2 && i == 12)
                    drain_reports();
                send_echo(pick_count(), (i < 8 && ph == 4) ? 0 : pick_gap());
            end
        end

        drain_reports();
        if (board.owed() != 0) begin
            board.errors += board.owed();
            $display("%0d report chars never arrived", board.owed());
        end
        $display("Checked %0d echo words, %0d report chars, %0d register writes.",
                 board.n_words, board.n_chars, board.n_settings);
        $display("Timeouts %0d, clamped %0d, alarms %0d, mismatches %0d.",
                 board.n_timeout, board.n_clamped, board.n_alarm, board.errors);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
